FILE: rtl/core/hpst_pkg.sv
// shared types and constants for the heartbeat peer session table
// no dependencies
`timescale 1ns / 1ps

package hpst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  // distance unit sizing
  localparam int SUM_W       = 34;
  localparam int SQRT_STEPS  = 17;
  localparam int PHASE_W     = 5;

  localparam logic [1:0] REQ_HEARTBEAT = 2'd0;
  localparam logic [1:0] REQ_DATA      = 2'd1;
  localparam logic [1:0] REQ_SWEEP     = 2'd2;
  localparam logic [1:0] REQ_SEND      = 2'd3;

  localparam logic [2:0] KIND_ACK      = 3'd0;
  localparam logic [2:0] KIND_DETECTED = 3'd1;
  localparam logic [2:0] KIND_DELIVER  = 3'd2;
  localparam logic [2:0] KIND_LOST     = 3'd3;
  localparam logic [2:0] KIND_SEND     = 3'd4;
  localparam logic [2:0] KIND_FULL     = 3'd5;

  localparam logic [2:0] REG_STATION_X = 3'd0;
  localparam logic [2:0] REG_STATION_Y = 3'd1;
  localparam logic [2:0] REG_STATION_Z = 3'd2;
  localparam logic [2:0] REG_STALE     = 3'd3;
  localparam logic [2:0] REG_WEAKEST   = 3'd4;

  typedef struct packed {
    logic [63:0] ident;
    logic [31:0] id;
    logic [47:0] addr;
    logic [31:0] seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        id;
    logic [47:0]        addr;
    logic signed [17:0] level;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_SCAN,
    ST_POST,
    ST_ACK,
    ST_FIN
  } state_t;

endpackage

FILE: rtl/core/hpst_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module hpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hpst_dist.sv
// distance to level unit: squares over a shared multiplier, then bitwise isqrt
// depends on hpst_pkg
`timescale 1ns / 1ps

module hpst_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [15:0] station_x,
  input  logic signed [15:0] station_y,
  input  logic signed [15:0] station_z,
  input  logic signed [15:0] peer_x,
  input  logic signed [15:0] peer_y,
  input  logic signed [15:0] peer_z,
  output logic               done,
  output logic signed [17:0] level
);
  import hpst_pkg::*;

  logic               run_r;
  logic               done_r;
  logic [PHASE_W-1:0] phase_r;
  logic signed [16:0] dx_r, dy_r, dz_r;
  logic [32:0]        prod_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   rem_r, res_r, bit_r;

  logic signed [16:0] op;
  logic signed [33:0] sq;
  logic [SUM_W:0]     trial;
  logic [16:0]        root;

  always_comb begin
    case (phase_r)
      PHASE_W'(0): op = dx_r;
      PHASE_W'(1): op = dy_r;
      default:     op = dz_r;
    endcase
  end

  assign sq    = op * op;
  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign root  = res_r[16:0];
  assign level = (root == 17'd0) ? -18'sd1 : -$signed({1'b0, root});
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      done_r <= !go && run_r && (phase_r == PHASE_W'(3 + SQRT_STEPS));
      if (go) begin
        run_r   <= 1'b1;
        phase_r <= '0;
        dx_r    <= 17'(station_x) - 17'(peer_x);
        dy_r    <= 17'(station_y) - 17'(peer_y);
        dz_r    <= 17'(station_z) - 17'(peer_z);
      end else if (run_r) begin
        phase_r <= phase_r + 1'b1;
        if (phase_r < PHASE_W'(3)) begin
          prod_r <= sq[32:0];
        end
        if (phase_r == PHASE_W'(1)) begin
          sum_r <= SUM_W'(prod_r);
        end else if (phase_r == PHASE_W'(2)) begin
          sum_r <= sum_r + SUM_W'(prod_r);
        end else if (phase_r == PHASE_W'(3)) begin
          rem_r <= sum_r + SUM_W'(prod_r);
          res_r <= '0;
          bit_r <= SUM_W'(1) << 32;
        end else if (phase_r > PHASE_W'(3)) begin
          // one restoring root step per cycle
          if ({1'b0, rem_r} >= trial) begin
            rem_r <= rem_r - trial[SUM_W-1:0];
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (phase_r == PHASE_W'(3 + SQRT_STEPS)) begin
            run_r <= 1'b0;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/core/heartbeat_peer_session_table.sv
// top level of the heartbeat peer session table: sequencer, apb registers, table ram
// depends on hpst_pkg, hpst_ram, hpst_dist
//
// channel   handshake                    payload
// input     start & !busy                in_req_type .. in_target_id
// result    out_valid, one cycle         out_result_kind .. out_last
// config    psel & penable & pwrite      paddr, pwdata (prdata on read)
//
// heartbeat: waits on the distance unit (3 squares on one multiplier, a final add,
// 17 root steps, done registered), then one table pass over the ram read port.
// data and single send: one pass. sweep and broadcast: one pass per visited entry
// of the ordered walk. reset clears valid bits and id counter and sets config to
// its defaults. results cannot be stalled; busy falls in the same cycle that the
// last result is shown on out_valid.
`timescale 1ns / 1ps

module heartbeat_peer_session_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [63:0]        in_peer_ident,
  input  logic [47:0]        in_peer_addr,
  input  logic signed [15:0] in_peer_x,
  input  logic signed [15:0] in_peer_y,
  input  logic signed [15:0] in_peer_z,
  input  logic [31:0]        in_now_ms,
  input  logic [31:0]        in_target_id,
  output logic               out_valid,
  output logic [2:0]         out_result_kind,
  output logic [31:0]        out_peer_id,
  output logic [47:0]        out_dest_addr,
  output logic signed [17:0] out_level,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hpst_pkg::*;

  // configuration
  logic signed [15:0] stx_r, sty_r, stz_r;
  logic [15:0]        stale_r;
  logic signed [17:0] weakest_r;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stx_r     <= '0;
      sty_r     <= '0;
      stz_r     <= '0;
      stale_r   <= 16'd2000;
      weakest_r <= -18'sd120;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_STATION_X: stx_r     <= pwdata[15:0];
        REG_STATION_Y: sty_r     <= pwdata[15:0];
        REG_STATION_Z: stz_r     <= pwdata[15:0];
        REG_STALE:     stale_r   <= pwdata[15:0];
        REG_WEAKEST:   weakest_r <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STATION_X: prdata = 32'(stx_r);
      REG_STATION_Y: prdata = 32'(sty_r);
      REG_STATION_Z: prdata = 32'(stz_r);
      REG_STALE:     prdata = {16'd0, stale_r};
      REG_WEAKEST:   prdata = 32'(weakest_r);
      default:       prdata = '0;
    endcase
  end

  // item registers
  state_t state_r, state_nxt;
  logic [1:0]         type_r;
  logic [63:0]        ident_r;
  logic [47:0]        addr_r;
  logic [31:0]        now_r;
  logic [31:0]        target_r;
  logic signed [17:0] level_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0]            id_ctr_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [NRES_W-1:0]      nres_r;

  // per pass search results
  logic             hit_r;
  logic [IDX_W-1:0] hit_slot_r;
  logic [31:0]      hit_id_r;
  logic [47:0]      hit_addr_r;
  logic             best_r;
  logic [IDX_W-1:0] best_slot_r;
  logic [31:0]      best_id_r;
  logic [47:0]      best_addr_r;
  logic [31:0]      best_seen_r;
  logic             prev_r;
  logic [IDX_W-1:0] prev_slot_r;
  logic [31:0]      prev_id_r;

  // one result held back so the final one can be marked
  logic    pend_r;
  result_t pend_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // distance unit
  logic               dist_done;
  logic signed [17:0] dist_level;

  hpst_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept && (in_req_type == REQ_HEARTBEAT)),
    .station_x (stx_r),
    .station_y (sty_r),
    .station_z (stz_r),
    .peer_x    (in_peer_x),
    .peer_y    (in_peer_y),
    .peer_z    (in_peer_z),
    .done      (dist_done),
    .level     (dist_level)
  );

  // table ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_ent;

  hpst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // lowest free slot
  logic             free_any;
  logic [IDX_W-1:0] free_slot;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any  = 1'b1;
        free_slot = IDX_W'(i);
      end
    end
  end

  logic [31:0] new_id;
  logic        ordered;
  logic        stale;
  logic        more;

  assign new_id  = (id_ctr_r == 32'hFFFF_FFFF) ? 32'd1 : id_ctr_r + 32'd1;
  assign ordered = (type_r == REQ_SWEEP) || (type_r == REQ_SEND && target_r == 32'd0);
  assign stale   = (now_r - best_seen_r) > {16'd0, stale_r};
  assign more    = best_r && (nres_r < NRES_W'(MAX_RESULTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == REQ_HEARTBEAT) ? ST_DIST : ST_SCAN;
        end
      end
      ST_DIST: begin
        if (dist_done) begin
          state_nxt = (dist_level < weakest_r) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (ordered) begin
          state_nxt = more ? ST_SCAN : ST_FIN;
        end else if (type_r == REQ_HEARTBEAT && !hit_r && free_any) begin
          state_nxt = ST_ACK;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_ACK:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  logic    push;
  result_t push_q;
  logic    take_new;
  logic    drop_best;

  always_comb begin
    push      = 1'b0;
    push_q    = '0;
    ram_we    = 1'b0;
    ram_waddr = hit_slot_r;
    ram_wdata = '{ident: ident_r, id: hit_id_r, addr: addr_r, seen: now_r};
    take_new  = 1'b0;
    drop_best = 1'b0;
    case (state_r)
      ST_POST: begin
        if (ordered) begin
          if (more) begin
            if (type_r == REQ_SEND) begin
              push   = 1'b1;
              push_q = '{kind: KIND_SEND, id: best_id_r, addr: best_addr_r, level: '0};
            end else if (stale) begin
              push      = 1'b1;
              push_q    = '{kind: KIND_LOST, id: best_id_r, addr: '0, level: '0};
              drop_best = 1'b1;
            end
          end
        end else if (type_r == REQ_HEARTBEAT) begin
          if (hit_r) begin
            ram_we = 1'b1;
            push   = 1'b1;
            push_q = '{kind: KIND_ACK, id: hit_id_r, addr: addr_r, level: level_r};
          end else if (!free_any) begin
            push   = 1'b1;
            push_q = '{kind: KIND_FULL, id: '0, addr: addr_r, level: '0};
          end else begin
            take_new  = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = free_slot;
            ram_wdata = '{ident: ident_r, id: new_id, addr: addr_r, seen: now_r};
            push      = 1'b1;
            push_q    = '{kind: KIND_DETECTED, id: new_id, addr: '0, level: '0};
          end
        end else if (hit_r) begin
          push = 1'b1;
          if (type_r == REQ_DATA) begin
            push_q = '{kind: KIND_DELIVER, id: hit_id_r, addr: '0, level: '0};
          end else begin
            push_q = '{kind: KIND_SEND, id: target_r, addr: hit_addr_r, level: '0};
          end
        end
      end
      ST_ACK: begin
        push   = 1'b1;
        push_q = '{kind: KIND_ACK, id: id_ctr_r, addr: addr_r, level: level_r};
      end
      default: ;
    endcase
  end

  // scan compare on the entry read last cycle
  logic [IDX_W-1:0] cmp_slot;
  logic             cmp_on;
  logic             cmp_hit;
  logic             cmp_after;
  logic             cmp_best;

  assign cmp_slot  = IDX_W'(cnt_r - 1'b1);
  assign cmp_on    = (state_r == ST_SCAN) && (cnt_r != '0) && valid_r[cmp_slot];
  assign cmp_hit   = (type_r == REQ_SEND) ? (rd_ent.id == target_r) : (rd_ent.ident == ident_r);
  assign cmp_after = !prev_r || (rd_ent.id > prev_id_r) ||
                     (rd_ent.id == prev_id_r && cmp_slot > prev_slot_r);
  assign cmp_best  = cmp_after && (!best_r || rd_ent.id < best_id_r);

  // the held result goes out when a new one arrives or at the end of the item
  logic emit;
  assign emit = pend_r && (push || state_r == ST_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      id_ctr_r  <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
      cnt_r     <= '0;
      hit_r     <= 1'b0;
      best_r    <= 1'b0;
      prev_r    <= 1'b0;
      nres_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        type_r   <= in_req_type;
        ident_r  <= in_peer_ident;
        addr_r   <= in_peer_addr;
        now_r    <= in_now_ms;
        target_r <= in_target_id;
        cnt_r    <= '0;
        prev_r   <= 1'b0;
        nres_r   <= '0;
      end

      if (dist_done) begin
        level_r <= dist_level;
      end

      if (state_r == ST_SCAN) begin
        cnt_r <= (cnt_r == CNT_W'(TABLE_DEPTH)) ? '0 : cnt_r + 1'b1;
        if (cnt_r == '0) begin
          hit_r  <= 1'b0;
          best_r <= 1'b0;
        end else if (cmp_on) begin
          if (cmp_hit && !hit_r) begin
            hit_r      <= 1'b1;
            hit_slot_r <= cmp_slot;
            hit_id_r   <= rd_ent.id;
            hit_addr_r <= rd_ent.addr;
          end
          if (cmp_best) begin
            best_r      <= 1'b1;
            best_slot_r <= cmp_slot;
            best_id_r   <= rd_ent.id;
            best_addr_r <= rd_ent.addr;
            best_seen_r <= rd_ent.seen;
          end
        end
      end

      if (state_r == ST_POST && ordered && more) begin
        prev_r      <= 1'b1;
        prev_slot_r <= best_slot_r;
        prev_id_r   <= best_id_r;
      end

      if (take_new) begin
        id_ctr_r              <= new_id;
        valid_r[free_slot]    <= 1'b1;
      end
      if (drop_best) begin
        valid_r[best_slot_r]  <= 1'b0;
      end
      if (push && ordered) begin
        nres_r <= nres_r + 1'b1;
      end

      // result transfer
      out_valid <= emit;
      if (push) begin
        pend_r <= 1'b1;
        pend_q <= push_q;
      end else if (state_r == ST_FIN) begin
        pend_r <= 1'b0;
      end
      if (emit) begin
        out_result_kind <= pend_q.kind;
        out_peer_id     <= pend_q.id;
        out_dest_addr   <= pend_q.addr;
        out_level       <= pend_q.level;
        out_last        <= !push;
      end
    end
  end

endmodule

FILE: tb/heartbeat_peer_session_table_test.sv
// self-checking testbench for heartbeat_peer_session_table: directed table, then random phases
// depends on hpst_pkg and the heartbeat_peer_session_table rtl
`timescale 1ns / 1ps

module heartbeat_peer_session_table_test;
  import hpst_pkg::*;

  typedef struct {
    logic [2:0]         kind;
    logic [31:0]        id;
    logic [47:0]        addr;
    logic signed [17:0] level;
    logic               last;
  } peer_result_t;

  typedef struct {
    logic [1:0]         req;
    logic [63:0]        ident;
    logic [47:0]        addr;
    logic signed [15:0] x, y, z;
    logic [31:0]        now;
    logic [31:0]        target;
    bit                 chk;
    logic [2:0]         ekind;
    logic [31:0]        eid;
    logic [47:0]        eaddr;
    logic signed [17:0] elevel;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [63:0] in_peer_ident = '0;
  logic [47:0] in_peer_addr = '0;
  logic signed [15:0] in_peer_x = '0, in_peer_y = '0, in_peer_z = '0;
  logic [31:0] in_now_ms = '0, in_target_id = '0;
  logic out_valid;
  logic [2:0] out_result_kind;
  logic [31:0] out_peer_id;
  logic [47:0] out_dest_addr;
  logic signed [17:0] out_level;
  logic out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heartbeat_peer_session_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_peer_ident(in_peer_ident), .in_peer_addr(in_peer_addr),
    .in_peer_x(in_peer_x), .in_peer_y(in_peer_y), .in_peer_z(in_peer_z),
    .in_now_ms(in_now_ms), .in_target_id(in_target_id),
    .out_valid(out_valid), .out_result_kind(out_result_kind), .out_peer_id(out_peer_id),
    .out_dest_addr(out_dest_addr), .out_level(out_level), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow of the block state
  logic signed [15:0] stn_x, stn_y, stn_z;
  logic [15:0]        stale_ms;
  logic signed [17:0] floor_level;
  bit                 sh_valid [TABLE_DEPTH];
  logic [63:0]        sh_ident [TABLE_DEPTH];
  logic [31:0]        sh_id    [TABLE_DEPTH];
  logic [47:0]        sh_addr  [TABLE_DEPTH];
  logic [31:0]        sh_seen  [TABLE_DEPTH];
  logic [31:0]        next_id;

  peer_result_t pending_results[$];
  peer_result_t fresh[$];
  int mismatches = 0;
  bit timed_out = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int slot_after(logic [31:0] pid, int ps);
    int best = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!sh_valid[i]) continue;
      if (ps >= 0 && (sh_id[i] < pid || (sh_id[i] == pid && i <= ps))) continue;
      if (best < 0 || sh_id[i] < sh_id[best]) best = i;
    end
    return best;
  endfunction

  function automatic int slot_of_ident(logic [63:0] ident);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (sh_valid[i] && sh_ident[i] == ident) return i;
    return -1;
  endfunction

  function automatic void add_result(logic [2:0] k, logic [31:0] id, logic [47:0] a,
                                     logic signed [17:0] lv);
    peer_result_t r;
    r.kind = k; r.id = id; r.addr = a; r.level = lv; r.last = 1'b0;
    fresh.push_back(r);
  endfunction

  // computes the results of one accepted transfer and updates the shadow table
  function automatic void predict_peer_results(stim_row_t it);
    longint dx, dy, dz, rdist, lvl;
    longint unsigned sq;
    int s, c, ps;
    int gone[$];
    logic [31:0] pid;
    fresh.delete();
    case (it.req)
      REQ_HEARTBEAT: begin
        dx = longint'(stn_x) - longint'(it.x);
        dy = longint'(stn_y) - longint'(it.y);
        dz = longint'(stn_z) - longint'(it.z);
        sq = dx * dx + dy * dy + dz * dz;
        rdist = longint'(int_root(sq));
        lvl = (rdist == 0) ? -1 : -rdist;
        if (lvl >= longint'(floor_level)) begin
          s = slot_of_ident(it.ident);
          if (s < 0) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (!sh_valid[i]) begin s = i; break; end
            if (s < 0) begin
              add_result(KIND_FULL, 32'd0, it.addr, 18'sd0);
            end else begin
              next_id = next_id + 1;
              if (next_id == 0) next_id = 1;
              sh_valid[s] = 1; sh_ident[s] = it.ident; sh_id[s] = next_id;
              add_result(KIND_DETECTED, next_id, 48'd0, 18'sd0);
            end
          end
          if (s >= 0) begin
            sh_addr[s] = it.addr;
            sh_seen[s] = it.now;
            add_result(KIND_ACK, sh_id[s], it.addr, lvl[17:0]);
          end
        end
      end
      REQ_DATA: begin
        s = slot_of_ident(it.ident);
        if (s >= 0) add_result(KIND_DELIVER, sh_id[s], 48'd0, 18'sd0);
      end
      REQ_SWEEP: begin
        pid = 0; ps = -1;
        while (fresh.size() < MAX_RESULTS) begin
          c = slot_after(pid, ps);
          if (c < 0) break;
          pid = sh_id[c]; ps = c;
          if (it.now - sh_seen[c] > {16'd0, stale_ms}) begin
            gone.push_back(c);
            add_result(KIND_LOST, sh_id[c], 48'd0, 18'sd0);
          end
        end
        foreach (gone[i]) sh_valid[gone[i]] = 0;
      end
      default: begin
        if (it.target != 0) begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (sh_valid[i] && sh_id[i] == it.target) begin
              add_result(KIND_SEND, it.target, sh_addr[i], 18'sd0);
              break;
            end
        end else begin
          pid = 0; ps = -1;
          while (fresh.size() < MAX_RESULTS) begin
            c = slot_after(pid, ps);
            if (c < 0) break;
            pid = sh_id[c]; ps = c;
            add_result(KIND_SEND, sh_id[c], sh_addr[c], 18'sd0);
          end
        end
      end
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) pending_results.push_back(fresh[i]);
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  // result checker
  always @(posedge clk) begin
    peer_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d id %0d",
                                out_result_kind, out_peer_id));
      end else begin
        e = pending_results.pop_front();
        if (out_result_kind !== e.kind || out_peer_id !== e.id || out_dest_addr !== e.addr ||
            out_level !== e.level || out_last !== e.last)
          flag_mismatch($sformatf(
            "exp kind %0d id %0d addr %h level %0d last %0d, got %0d %0d %h %0d %0d",
            e.kind, e.id, e.addr, e.level, e.last, out_result_kind, out_peer_id,
            out_dest_addr, out_level, out_last));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_STATION_X: stn_x = val[15:0];
      REG_STATION_Y: stn_y = val[15:0];
      REG_STATION_Z: stn_z = val[15:0];
      REG_STALE:     stale_ms = val[15:0];
      default:       floor_level = val[17:0];
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // sender pause: all results in and the block idle
  task automatic drain;
    @(negedge clk);
    start = 0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic issue(stim_row_t it);
    int gap;
    @(negedge clk);
    in_req_type = it.req; in_peer_ident = it.ident; in_peer_addr = it.addr;
    in_peer_x = it.x; in_peer_y = it.y; in_peer_z = it.z;
    in_now_ms = it.now; in_target_id = it.target;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_peer_results(it);
    if (it.chk) begin
      if (fresh.size() == 0 || fresh[0].kind !== it.ekind || fresh[0].id !== it.eid ||
          fresh[0].addr !== it.eaddr || fresh[0].level !== it.elevel)
        flag_mismatch($sformatf("directed row req %0d: first result not as listed", it.req));
    end
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic stim_row_t row(logic [1:0] rq, logic [63:0] idt, logic [47:0] ad,
                                    int x, int y, int z, logic [31:0] nw, logic [31:0] tg);
    stim_row_t r;
    r.req = rq; r.ident = idt; r.addr = ad; r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.now = nw; r.target = tg; r.chk = 0;
    r.ekind = 0; r.eid = 0; r.eaddr = 0; r.elevel = 0;
    return r;
  endfunction

  function automatic stim_row_t with_exp(stim_row_t r, logic [2:0] k, logic [31:0] id,
                                         logic [47:0] a, int lv);
    r.chk = 1; r.ekind = k; r.eid = id; r.eaddr = a; r.elevel = 18'(lv);
    return r;
  endfunction

  localparam logic [63:0] ID_A = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] ID_B = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] ID_C = 64'h0;

  initial begin
    #20ms;
    timed_out = 1;
    $display("heartbeat_peer_session_table_test failed");
    $finish;
  end

  initial begin
    stim_row_t dir[$];
    stim_row_t it;
    logic [63:0] idents[24];
    logic [31:0] now_base;
    int pick;
    stn_x = 0; stn_y = 0; stn_z = 0; stale_ms = 16'd2000; floor_level = -18'sd120;
    foreach (sh_valid[i]) sh_valid[i] = 0;
    next_id = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    dir.push_back(row(REQ_DATA, ID_A, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(REQ_SEND, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(with_exp(row(REQ_HEARTBEAT, ID_A, 48'hffff_ffff_ffff, 0, 0, 0, 100, 0),
                           KIND_DETECTED, 1, 0, 0));
    dir.push_back(with_exp(row(REQ_HEARTBEAT, ID_A, 48'h0000_1234_5678, 3, 4, 0, 100, 0),
                           KIND_ACK, 1, 48'h0000_1234_5678, -5));
    dir.push_back(with_exp(row(REQ_HEARTBEAT, ID_B, 48'h8000_0000_0001, 120, 0, 0, 50, 0),
                           KIND_DETECTED, 2, 0, 0));
    dir.push_back(row(REQ_HEARTBEAT, ID_C, 1, 121, 0, 0, 7, 0));
    dir.push_back(row(REQ_HEARTBEAT, ID_C, 2, -32768, -32768, -32768, 7, 0));
    dir.push_back(row(REQ_HEARTBEAT, ID_C, 3, 32767, 32767, 32767, 7, 0));
    dir.push_back(with_exp(row(REQ_DATA, ID_A, 0, 0, 0, 0, 0, 0), KIND_DELIVER, 1, 0, 0));
    dir.push_back(row(REQ_DATA, ID_C, 0, 0, 0, 0, 0, 0));
    dir.push_back(with_exp(row(REQ_SEND, 0, 0, 0, 0, 0, 0, 2),
                           KIND_SEND, 2, 48'h8000_0000_0001, 0));
    dir.push_back(row(REQ_SEND, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
    dir.push_back(row(REQ_SEND, ID_B, 0, 0, 0, 0, 0, 0));
    dir.push_back(with_exp(row(REQ_SWEEP, 0, 0, 0, 0, 0, 2100, 0), KIND_LOST, 2, 0, 0));
    dir.push_back(with_exp(row(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0), KIND_LOST, 1, 0, 0));
    foreach (dir[i]) issue(dir[i]);
    drain();

    foreach (idents[i]) idents[i] = {$urandom, $urandom};
    now_base = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_STATION_X, 32'hffff_8000); write_reg(REG_STATION_Y, 32'h7fff);
          write_reg(REG_STATION_Z, 32'hffff_8000); write_reg(REG_STALE, 0);
          write_reg(REG_WEAKEST, 32'hfffe_0000);
        end
        1: begin
          write_reg(REG_STATION_X, 0); write_reg(REG_STATION_Y, 0);
          write_reg(REG_STATION_Z, 0); write_reg(REG_STALE, 32'hffff);
          write_reg(REG_WEAKEST, 32'h3_0000 | $urandom_range(0, 16'hffff));
        end
        2: begin
          write_reg(REG_STATION_X, $urandom); write_reg(REG_STATION_Y, $urandom);
          write_reg(REG_STATION_Z, $urandom); write_reg(REG_STALE, $urandom_range(0, 3000));
          write_reg(REG_WEAKEST, 32'hfffe_0000);
        end
        3: begin
          write_reg(REG_WEAKEST, 0);
        end
        default: begin
          write_reg(REG_STALE, 2000);
          write_reg(REG_WEAKEST, 32'hfffe_0000 | $urandom_range(0, 32'h1_ffff));
        end
      endcase
      for (int n = 0; n < (ph == 3 ? 12 : 37); n++) begin
        now_base += $urandom_range(0, 1500);
        it = row(REQ_HEARTBEAT, 0, 48'({$urandom, $urandom}), 0, 0, 0, now_base, 0);
        pick = $urandom_range(0, 99);
        it.ident = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                               : idents[$urandom_range(0, 23)];
        if (pick < 45) begin
          it.req = REQ_HEARTBEAT;
          it.x = 16'($urandom); it.y = 16'($urandom); it.z = 16'($urandom);
          if ($urandom_range(0, 2) == 0) begin
            it.x = 16'(stn_x + $signed($urandom_range(0, 60)) - 30);
            it.y = stn_y; it.z = stn_z;
          end
          if ($urandom_range(0, 9) == 0) it.now = $urandom;
        end else if (pick < 65) begin
          it.req = REQ_DATA;
        end else if (pick < 80) begin
          it.req = REQ_SWEEP;
          if ($urandom_range(0, 7) == 0) it.now = $urandom;
        end else begin
          it.req = REQ_SEND;
          case ($urandom_range(0, 3))
            0: it.target = 0;
            1: it.target = $urandom;
            default: it.target = $urandom_range(1, next_id + 1);
          endcase
        end
        issue(it);
      end
      drain();
    end

    drain();
    if (mismatches == 0 && !timed_out)
      $display("heartbeat_peer_session_table_test passed");
    else
      $display("heartbeat_peer_session_table_test failed");
    $finish;
  end

endmodule
